FILE: rtl/core/jet_pkg.sv
// Shared types, constants and fixed-point helpers for the Julia escape-time block.
// Used by every module under rtl/core; depends on nothing else.
package jet_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int ITER_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int COORD_W  = 32;
    localparam int BUDGET_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W    = 40;
    localparam int HALF_W   = ACC_W / 2;
    localparam int PROD_W   = 2 * ACC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

    localparam logic signed [COORD_W-1:0]  JULIA_RE_RST       = -32'sd1879048192;
    localparam logic signed [COORD_W-1:0]  JULIA_IM_RST       = 32'sd0;
    localparam logic        [BUDGET_W-1:0] MAX_ITERATIONS_RST = 16'd64;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0]  point_re;
        logic signed [COORD_W-1:0]  point_im;
        logic        [BUDGET_W-1:0] budget;
        logic                       skip;
    } jet_entry_t;

    function automatic logic signed [ACC_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > PROD_W'(ACC_MAX))
            r = ACC_MAX;
        else if (v < PROD_W'(ACC_MIN))
            r = ACC_MIN;
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1])
            r = v[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/jet_front.sv
// Front end of the Julia escape-time block: takes point transactions into a holding
// register and marks points whose budget is zero. Depends on jet_pkg.
module jet_front #(
    parameter int ITER_WIDTH = jet_pkg::ITER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  logic signed [jet_pkg::COORD_W-1:0]  point_re,
    input  logic signed [jet_pkg::COORD_W-1:0]  point_im,
    input  logic        [jet_pkg::BUDGET_W-1:0] max_iterations,
    input  logic                                q_full,
    output logic                                q_push,
    output jet_pkg::jet_entry_t                 q_entry
);

    logic                slot_valid_reg;
    logic                slot_valid_next;
    jet_pkg::jet_entry_t slot_reg;
    logic                accept;

    assign point_stall = slot_valid_reg && q_full;
    assign accept      = point_valid && !point_stall;
    assign q_push      = slot_valid_reg && !q_full;
    assign q_entry     = slot_reg;

    assign slot_valid_next = accept || (slot_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg.point_re <= point_re;
            slot_reg.point_im <= point_im;
            slot_reg.budget   <= max_iterations;
            slot_reg.skip     <= (ITER_WIDTH'(max_iterations) == '0);
        end
    end

endmodule

FILE: rtl/core/jet_queue.sv
// Short register queue between the front end and the iteration engine.
// Depends on jet_pkg for the entry type.
module jet_queue #(
    parameter int DEPTH = jet_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jet_pkg::jet_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output jet_pkg::jet_entry_t pop_entry,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jet_pkg::jet_entry_t store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

FILE: rtl/core/jet_engine.sv
// Back end of the Julia escape-time block: a three-stage z*z + k datapath run as an
// iteration loop, plus the result register. Depends on jet_pkg.
module jet_engine #(
    parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF,
    parameter int ITER_WIDTH = jet_pkg::ITER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  jet_pkg::jet_entry_t                 q_entry,
    output logic                                q_pop,
    input  logic signed [jet_pkg::COORD_W-1:0]  julia_re,
    input  logic signed [jet_pkg::COORD_W-1:0]  julia_im,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic        [jet_pkg::BUDGET_W-1:0] iterations_left
);

    localparam int ACC_W  = jet_pkg::ACC_W;
    localparam int HALF_W = jet_pkg::HALF_W;
    localparam int PROD_W = jet_pkg::PROD_W;
    localparam int LO_W   = ACC_W + HALF_W + 1;
    localparam int HI_W   = ACC_W + HALF_W;
    localparam int CMP_W  = (FRAC_BITS + 3 > ACC_W + 1) ? FRAC_BITS + 3 : ACC_W + 1;
    localparam logic [CMP_W-1:0] THRESH = {{(CMP_W-3){1'b0}}, 3'b100} << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_UPD  = 5'b01000,
        S_WAIT = 5'b10000
    } eng_state_t;

    eng_state_t state_reg;
    eng_state_t state_next;
    logic [ITER_WIDTH-1:0] count_reg;
    logic [ITER_WIDTH-1:0] count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [jet_pkg::BUDGET_W-1:0] out_reg;
    logic [jet_pkg::BUDGET_W-1:0] out_next;

    logic signed [ACC_W-1:0] z_re_reg;
    logic signed [ACC_W-1:0] z_re_next;
    logic signed [ACC_W-1:0] z_im_reg;
    logic signed [ACC_W-1:0] z_im_next;

    logic signed [LO_W-1:0] rr_lo_reg;
    logic signed [HI_W-1:0] rr_hi_reg;
    logic signed [LO_W-1:0] ii_lo_reg;
    logic signed [HI_W-1:0] ii_hi_reg;
    logic signed [LO_W-1:0] ri_lo_reg;
    logic signed [HI_W-1:0] ri_hi_reg;

    logic signed [PROD_W-1:0] rr_full;
    logic signed [PROD_W-1:0] ii_full;
    logic signed [PROD_W-1:0] ri_full;
    logic signed [ACC_W-1:0]  sq_re_reg;
    logic signed [ACC_W-1:0]  sq_im_reg;
    logic signed [ACC_W-1:0]  cross_reg;

    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] z_re_upd;
    logic signed [ACC_W-1:0] z_im_upd;
    logic        [CMP_W-1:0] mag_sq;
    logic                    keep_going;
    logic                    out_free;

    assign result_valid    = out_valid_reg;
    assign iterations_left = out_reg;
    assign out_free        = !out_valid_reg || !result_stall;
    assign q_pop           = (state_reg == S_IDLE) && !q_empty;

    // Stage two: recombine partial products, floor-shift and saturate.
    assign rr_full = (PROD_W'(rr_hi_reg) <<< HALF_W) + PROD_W'(rr_lo_reg);
    assign ii_full = (PROD_W'(ii_hi_reg) <<< HALF_W) + PROD_W'(ii_lo_reg);
    assign ri_full = (PROD_W'(ri_hi_reg) <<< HALF_W) + PROD_W'(ri_lo_reg);

    // Stage three: new z and the escape test on the squares of the previous z.
    assign diff     = jet_pkg::sat_sum((ACC_W+1)'(sq_re_reg) - (ACC_W+1)'(sq_im_reg));
    assign z_re_upd = jet_pkg::sat_sum((ACC_W+1)'(diff) + (ACC_W+1)'(julia_re));
    assign z_im_upd = jet_pkg::sat_sum((ACC_W+1)'(cross_reg) + (ACC_W+1)'(julia_im));
    assign mag_sq   = CMP_W'($unsigned(sq_re_reg)) + CMP_W'($unsigned(sq_im_reg));
    assign keep_going = (mag_sq <= THRESH) && (count_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        z_re_next      = z_re_reg;
        z_im_next      = z_im_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    z_re_next  = ACC_W'(q_entry.point_re);
                    z_im_next  = ACC_W'(q_entry.point_im);
                    count_next = ITER_WIDTH'(q_entry.budget);
                    state_next = q_entry.skip ? S_WAIT : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                z_re_next = z_re_upd;
                z_im_next = z_im_upd;
                if (keep_going)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = jet_pkg::BUDGET_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        out_reg   <= out_next;
        z_re_reg  <= z_re_next;
        z_im_reg  <= z_im_next;
        rr_lo_reg <= LO_W'(z_re_reg) * LO_W'($signed({1'b0, z_re_reg[HALF_W-1:0]}));
        rr_hi_reg <= HI_W'(z_re_reg) * HI_W'($signed(z_re_reg[ACC_W-1:HALF_W]));
        ii_lo_reg <= LO_W'(z_im_reg) * LO_W'($signed({1'b0, z_im_reg[HALF_W-1:0]}));
        ii_hi_reg <= HI_W'(z_im_reg) * HI_W'($signed(z_im_reg[ACC_W-1:HALF_W]));
        ri_lo_reg <= LO_W'(z_re_reg) * LO_W'($signed({1'b0, z_im_reg[HALF_W-1:0]}));
        ri_hi_reg <= HI_W'(z_re_reg) * HI_W'($signed(z_im_reg[ACC_W-1:HALF_W]));
        sq_re_reg <= jet_pkg::sat_prod(rr_full >>> FRAC_BITS);
        sq_im_reg <= jet_pkg::sat_prod(ii_full >>> FRAC_BITS);
        cross_reg <= jet_pkg::sat_prod(ri_full >>> (FRAC_BITS - 1));
    end

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && keep_going) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("iteration count did not step down by one");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished point was not moved to the result register");

endmodule

FILE: rtl/core/julia_escape_time.sv
// Top level of the Julia escape-time block: configuration registers, front end,
// queue and iteration engine. Depends on jet_pkg, jet_front, jet_queue, jet_engine.
//
// Each point runs z <- z*z + k in 40-bit fixed point on a three-stage datapath (partial
// products, recombine and saturate, update and escape test); points whose budget is zero
// bypass the datapath. The default budget is 64. A two-deep queue and an input holding
// register let new points arrive while the engine is busy, and the result register holds
// a finished transaction while the next point is being worked on.
module julia_escape_time #(
    parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF,
    parameter int ITER_WIDTH = jet_pkg::ITER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [jet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [jet_pkg::COORD_W-1:0]   cfg_data,
    input  logic                                 point_valid,
    output logic                                 point_stall,
    input  logic signed [jet_pkg::COORD_W-1:0]   point_re,
    input  logic signed [jet_pkg::COORD_W-1:0]   point_im,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic        [jet_pkg::BUDGET_W-1:0]  iterations_left
);

    logic signed [jet_pkg::COORD_W-1:0]  julia_re_reg;
    logic signed [jet_pkg::COORD_W-1:0]  julia_im_reg;
    logic        [jet_pkg::BUDGET_W-1:0] max_iterations_reg;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    jet_pkg::jet_entry_t q_in;
    jet_pkg::jet_entry_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            julia_re_reg       <= jet_pkg::JULIA_RE_RST;
            julia_im_reg       <= jet_pkg::JULIA_IM_RST;
            max_iterations_reg <= jet_pkg::MAX_ITERATIONS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jet_pkg::CFG_JULIA_RE:       julia_re_reg <= $signed(cfg_data);
                jet_pkg::CFG_JULIA_IM:       julia_im_reg <= $signed(cfg_data);
                jet_pkg::CFG_MAX_ITERATIONS:
                    max_iterations_reg <= cfg_data[jet_pkg::BUDGET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    jet_front #(
        .ITER_WIDTH (ITER_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_re       (point_re),
        .point_im       (point_im),
        .max_iterations (max_iterations_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_in)
    );

    jet_queue #(
        .DEPTH (jet_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    jet_engine #(
        .FRAC_BITS  (FRAC_BITS),
        .ITER_WIDTH (ITER_WIDTH)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_entry         (q_out),
        .q_pop           (q_pop),
        .julia_re        (julia_re_reg),
        .julia_im        (julia_im_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .iterations_left (iterations_left)
    );

endmodule
